// ===== design/mrcrd_pkg.sv =====
`timescale 1ns / 1ps

package mrcrd_pkg;

	// Field widths
	localparam int OP_W    = 2;
	localparam int RANGE_W = 11;
	localparam int INDEX_W = 10;
	localparam int WORD_W  = 64;
	localparam int STAT_W  = 2;

	// Largest matrix dimension; a range may not stop beyond it
	localparam int MAX_DIM = 1024;

	// Default depth of the range table
	localparam int MAX_RANGES_DEF = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
	localparam logic [OP_W-1:0] OP_ELEMENT = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_KEPT    = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;
	localparam logic [STAT_W-1:0] ST_REJECT  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [RANGE_W-1:0] range_first;
		logic [RANGE_W-1:0] range_stop;
		logic [INDEX_W-1:0] row_index;
		logic [INDEX_W-1:0] col_index;
		logic [WORD_W-1:0]  element_word;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [INDEX_W-1:0] new_row;
		logic [INDEX_W-1:0] new_col;
		logic [WORD_W-1:0]  out_word;
	} result_t;

endpackage

// ===== design/matrix_row_col_range_deleter.sv =====
`timescale 1ns / 1ps

// Row/column range deleter for a square matrix streamed one element per request.
// Input channel (item_valid/item_ready/item): a request either clears the range
// table, appends one removal range [range_first, range_stop), or carries one
// matrix element. Ranges must be appended in ascending, non-overlapping order;
// a bad append or an append to a full table answers "rejected" and changes
// nothing. An element whose row or column lies in a stored range is dropped;
// otherwise it leaves with both indices compacted by the removed lengths below.
// Output channel (result_valid/result_ready/result): exactly one result per
// request, in request order.
// A request passes through the input register, then the result register, before
// result_valid rises. Throughput: one request per cycle while the receiver takes
// results; the table lookup is a parallel compare over all MAX_RANGES entries
// and a pick of the running total of removed lengths.
// A table update takes effect for the very next request.
// Reset empties the table and both pipeline stages. When the receiver stalls,
// the result register holds and the input register fills behind it; item_ready
// then drops until the result is taken.
module matrix_row_col_range_deleter #(
	parameter int MAX_RANGES = mrcrd_pkg::MAX_RANGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mrcrd_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output mrcrd_pkg::result_t result
);

	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	// Pipeline registers
	logic               valid_s1;
	mrcrd_pkg::item_t   item_s1;
	logic               res_valid_q;
	mrcrd_pkg::result_t res_q;

	// Range table: each lane compared in parallel; no reset, read only below count
	logic [mrcrd_pkg::RANGE_W-1:0] start_q [MAX_RANGES];
	logic [mrcrd_pkg::RANGE_W-1:0] end_q   [MAX_RANGES];
	logic [mrcrd_pkg::INDEX_W-1:0] cum_q   [MAX_RANGES];
	logic [CNT_W-1:0]              count_q;
	logic [mrcrd_pkg::RANGE_W-1:0] last_end_q;
	logic [mrcrd_pkg::INDEX_W-1:0] total_q;

	logic               out_free;
	logic               adv_s1;
	logic               append_bad;
	logic               append_ok;
	logic               clear_now;
	logic               row_hit;
	logic               col_hit;
	logic [mrcrd_pkg::INDEX_W-1:0] row_removed;
	logic [mrcrd_pkg::INDEX_W-1:0] col_removed;
	logic [mrcrd_pkg::INDEX_W-1:0] new_total;
	mrcrd_pkg::result_t res_d;

	// Handshake
	assign out_free     = !res_valid_q || result_ready;
	assign adv_s1       = valid_s1 && out_free;
	assign item_ready   = !valid_s1 || out_free;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Running total of removed lengths including the range being appended
	assign new_total = total_q
		+ mrcrd_pkg::INDEX_W'(item_s1.range_stop - item_s1.range_first);

	// Append check
	always_comb begin
		append_bad = (count_q >= CNT_W'(MAX_RANGES))
			|| (item_s1.range_first < last_end_q)
			|| (item_s1.range_first > item_s1.range_stop)
			|| (32'(item_s1.range_stop) > 32'(mrcrd_pkg::MAX_DIM));
		append_ok = adv_s1 && (item_s1.operation == mrcrd_pkg::OP_APPEND) && !append_bad;
		clear_now = adv_s1 && (item_s1.operation == mrcrd_pkg::OP_CLEAR);
	end

	// Parallel lookup of row and column against every valid lane; range ends
	// ascend, so the removed length is the running total of the last lane that
	// ends at or below the index
	always_comb begin
		logic [mrcrd_pkg::RANGE_W-1:0] row_x;
		logic [mrcrd_pkg::RANGE_W-1:0] col_x;
		logic                          lane_on;
		logic [MAX_RANGES-1:0]         row_le;
		logic [MAX_RANGES-1:0]         col_le;
		logic [MAX_RANGES-1:0]         row_last;
		logic [MAX_RANGES-1:0]         col_last;
		row_x       = {1'b0, item_s1.row_index};
		col_x       = {1'b0, item_s1.col_index};
		row_hit     = 1'b0;
		col_hit     = 1'b0;
		row_le      = '0;
		col_le      = '0;
		row_removed = '0;
		col_removed = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			lane_on = (CNT_W'(k) < count_q);
			if (lane_on && row_x >= start_q[k] && row_x < end_q[k])
				row_hit = 1'b1;
			if (lane_on && col_x >= start_q[k] && col_x < end_q[k])
				col_hit = 1'b1;
			row_le[k] = lane_on && (end_q[k] <= row_x);
			col_le[k] = lane_on && (end_q[k] <= col_x);
		end
		// Lanes below the index form a prefix; keep only its top lane
		row_last = row_le & ~(row_le >> 1);
		col_last = col_le & ~(col_le >> 1);
		for (int k = 0; k < MAX_RANGES; k++) begin
			row_removed = row_removed | ({mrcrd_pkg::INDEX_W{row_last[k]}} & cum_q[k]);
			col_removed = col_removed | ({mrcrd_pkg::INDEX_W{col_last[k]}} & cum_q[k]);
		end
	end

	// Result
	always_comb begin
		res_d = '0;
		case (item_s1.operation)
			mrcrd_pkg::OP_APPEND: begin
				res_d.status = append_bad ? mrcrd_pkg::ST_REJECT : mrcrd_pkg::ST_DONE;
			end
			mrcrd_pkg::OP_ELEMENT: begin
				if (row_hit || col_hit) begin
					res_d.status = mrcrd_pkg::ST_DROPPED;
				end else begin
					res_d.status   = mrcrd_pkg::ST_KEPT;
					res_d.new_row  = item_s1.row_index - row_removed;
					res_d.new_col  = item_s1.col_index - col_removed;
					res_d.out_word = item_s1.element_word;
				end
			end
			default: begin
				res_d.status = mrcrd_pkg::ST_DONE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			count_q     <= '0;
			last_end_q  <= '0;
			total_q     <= '0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (out_free)
				res_valid_q <= valid_s1;
			if (clear_now) begin
				count_q    <= '0;
				last_end_q <= '0;
				total_q    <= '0;
			end else if (append_ok) begin
				count_q    <= count_q + CNT_W'(1);
				last_end_q <= item_s1.range_stop;
				total_q    <= new_total;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
		if (adv_s1)
			res_q <= res_d;
	end

	// Table write at the lane selected by the fill count
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RANGES; k++) begin
			if (append_ok && count_q == CNT_W'(k)) begin
				start_q[k] <= item_s1.range_first;
				end_q[k]   <= item_s1.range_stop;
				cum_q[k]   <= new_total;
			end
		end
	end

endmodule
